// File: rtl/core/block_index_pool_allocator_assert.svh
// Assertion macros used by the checker of the index pool allocator.
`ifndef BLOCK_INDEX_POOL_ALLOCATOR_ASSERT_SVH
`define BLOCK_INDEX_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define BIPA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bipa: implication check failed");

// Next-cycle implication.
`define BIPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bipa: next-cycle check failed");

// Implication after a fixed number of cycles.
`define BIPA_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("bipa: delayed check failed");

`endif

// File: rtl/core/bipa_pkg.sv
`default_nettype none

package bipa_pkg;

   localparam int OP_W     = 3;
   localparam int INDEX_W  = 10;
   localparam int COUNT_W  = 11;
   localparam int CHUNKS_W = 7;
   localparam int STATUS_W = 2;

   localparam int MAX_BLOCKS_DEFAULT   = 1024;
   localparam int CHUNK_BLOCKS_DEFAULT = 16;

   localparam logic [CHUNKS_W-1:0] MAX_CHUNKS_RESET = 7'd64;

   localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
   localparam logic [OP_W-1:0] OP_RELEASE = 3'd1;
   localparam logic [OP_W-1:0] OP_REWIND  = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_HELD  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [INDEX_W-1:0] target_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  granted_index;
      logic                is_held;
      logic [COUNT_W-1:0]  held_count;
      logic [COUNT_W-1:0]  high_water;
      logic [CHUNKS_W-1:0] chunks_in_use;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/core/block_index_pool_allocator.sv
`default_nettype none
// Block index pool allocator.
// Requests arrive on start/req_data and are taken at a clock edge where start
// is high and busy is low. Operations: allocate, release, rewind, clear and
// query. Each request produces exactly one response transaction on rsp_data,
// marked by rsp_valid for a single cycle; the receiver cannot stall it.
// The block takes no new request while it is busy with the last one. The free
// stack and allocation bitmap memories set this order: the accepting edge reads
// them, and the execute cycle that follows computes, writes back and registers
// the response at its end. Busy covers that execute cycle, so no two accesses
// to the same entry overlap. The max_chunks register resets to 64 and is written
// through csr_we/csr_wdata; the user must write it only when the block is idle,
// which the block itself does not enforce. Reset clears all counters and
// pointers; no memory sweep is needed, because only bitmap entries below the
// bump pointer are ever read back, and those are always written after the
// last clear or rewind.
module block_index_pool_allocator #(
   parameter int MAX_BLOCKS   = bipa_pkg::MAX_BLOCKS_DEFAULT,
   parameter int CHUNK_BLOCKS = bipa_pkg::CHUNK_BLOCKS_DEFAULT
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   output logic                          busy,
   input  bipa_pkg::req_type             req_data,
   output logic                          rsp_valid,
   output bipa_pkg::rsp_type             rsp_data,
   input  wire                           csr_we,
   input  wire [bipa_pkg::CHUNKS_W-1:0]  csr_wdata
);

   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int CAP_W  = $clog2(MAX_BLOCKS + CHUNK_BLOCKS + 1);
   localparam int CHK_W  = $clog2(MAX_BLOCKS / CHUNK_BLOCKS + 2);
   localparam int CMP_W  = (CHK_W > bipa_pkg::CHUNKS_W) ? CHK_W : bipa_pkg::CHUNKS_W;
   localparam int TCMP_W = (CNT_W > bipa_pkg::INDEX_W) ? CNT_W : bipa_pkg::INDEX_W;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type                     state_ff, state_in;
   logic [bipa_pkg::OP_W-1:0]     op_ff;
   logic [bipa_pkg::INDEX_W-1:0]  target_ff;
   logic [bipa_pkg::CHUNKS_W-1:0] max_chunks_ff;
   logic [CNT_W-1:0]              depth_ff, depth_in;
   logic [CNT_W-1:0]              bump_ff, bump_in;
   logic [CNT_W-1:0]              live_ff, live_in;
   logic [CNT_W-1:0]              peak_ff, peak_in;
   logic [CHK_W-1:0]              chunk_ff, chunk_in;
   logic [CAP_W-1:0]              cap_ff, cap_in;
   logic                          rsp_valid_ff;
   bipa_pkg::rsp_type             rsp_ff, rsp_in;

   logic [IDX_W-1:0]              stack_mem [MAX_BLOCKS];
   logic                          bit_mem [MAX_BLOCKS];
   logic [IDX_W-1:0]              stack_rd_ff;
   logic                          bit_rd_ff;

   logic                          accept;
   logic                          exec;
   logic [CNT_W-1:0]              pop_ptr;
   logic                          target_held;
   logic                          stack_empty;
   logic                          at_cap;
   logic                          chunk_room;
   logic                          pool_room;
   logic                          bump_ok;
   logic                          alloc_ok;
   logic                          release_ok;
   logic [IDX_W-1:0]              alloc_idx;
   logic [CNT_W-1:0]              bump_inc;
   logic                          stack_we;
   logic                          bit_we;
   logic [IDX_W-1:0]              bit_waddr;
   logic                          bit_wdata;

   assign busy      = (state_ff == S_EXEC);
   assign accept    = start && (state_ff == S_IDLE);
   assign exec      = (state_ff == S_EXEC);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pop_ptr   = depth_ff - CNT_W'(1);

   // Decisions for the request held in the execute cycle.
   assign target_held = (TCMP_W'(target_ff) < TCMP_W'(bump_ff)) && bit_rd_ff;
   assign stack_empty = (depth_ff == '0);
   assign at_cap      = (CAP_W'(bump_ff) >= cap_ff);
   assign chunk_room  = (CMP_W'(chunk_ff) < CMP_W'(max_chunks_ff));
   assign pool_room   = ((cap_ff + CAP_W'(CHUNK_BLOCKS)) <= CAP_W'(MAX_BLOCKS));
   assign bump_ok     = (bump_ff < CNT_W'(MAX_BLOCKS));
   assign alloc_ok    = !stack_empty || ((!at_cap || (chunk_room && pool_room)) && bump_ok);
   assign alloc_idx   = stack_empty ? bump_ff[IDX_W-1:0] : stack_rd_ff;
   assign release_ok  = target_held && (depth_ff < CNT_W'(MAX_BLOCKS));
   assign bump_inc    = bump_ff + CNT_W'(1);

   always_comb begin
      state_in  = state_ff;
      depth_in  = depth_ff;
      bump_in   = bump_ff;
      live_in   = live_ff;
      peak_in   = peak_ff;
      chunk_in  = chunk_ff;
      cap_in    = cap_ff;
      stack_we  = 1'b0;
      bit_we    = 1'b0;
      bit_waddr = target_ff[IDX_W-1:0];
      bit_wdata = 1'b0;
      rsp_in    = rsp_ff;
      if (accept) begin
         state_in = S_EXEC;
      end
      if (exec) begin
         state_in             = S_IDLE;
         rsp_in.status        = bipa_pkg::ST_OK;
         rsp_in.granted_index = '0;
         rsp_in.is_held       = 1'b0;
         unique case (op_ff)
            bipa_pkg::OP_ALLOC: begin
               // Growth is committed whenever it is allowed.
               if (stack_empty && at_cap && chunk_room && pool_room) begin
                  chunk_in = chunk_ff + CHK_W'(1);
                  cap_in   = cap_ff + CAP_W'(CHUNK_BLOCKS);
               end
               if (alloc_ok) begin
                  if (stack_empty) begin
                     bump_in = bump_inc;
                     if (bump_inc > peak_ff) begin
                        peak_in = bump_inc;
                     end
                  end else begin
                     depth_in = pop_ptr;
                  end
                  if (live_ff < CNT_W'(MAX_BLOCKS)) begin
                     live_in = live_ff + CNT_W'(1);
                  end
                  bit_we               = 1'b1;
                  bit_waddr            = alloc_idx;
                  bit_wdata            = 1'b1;
                  rsp_in.granted_index = bipa_pkg::INDEX_W'(alloc_idx);
               end else begin
                  rsp_in.status = bipa_pkg::ST_EXHAUSTED;
               end
            end
            bipa_pkg::OP_RELEASE: begin
               if (release_ok) begin
                  stack_we = 1'b1;
                  bit_we   = 1'b1;
                  depth_in = depth_ff + CNT_W'(1);
                  if (live_ff != '0) begin
                     live_in = live_ff - CNT_W'(1);
                  end
               end else begin
                  rsp_in.status = bipa_pkg::ST_NOT_HELD;
               end
            end
            bipa_pkg::OP_REWIND: begin
               depth_in = '0;
               bump_in  = '0;
               live_in  = '0;
            end
            bipa_pkg::OP_CLEAR: begin
               depth_in = '0;
               bump_in  = '0;
               live_in  = '0;
               peak_in  = '0;
               chunk_in = '0;
               cap_in   = '0;
            end
            bipa_pkg::OP_QUERY: begin
               rsp_in.is_held = target_held;
            end
            default: begin
            end
         endcase
         rsp_in.held_count    = bipa_pkg::COUNT_W'(live_in);
         rsp_in.high_water    = bipa_pkg::COUNT_W'(peak_in);
         rsp_in.chunks_in_use = bipa_pkg::CHUNKS_W'(chunk_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         max_chunks_ff <= bipa_pkg::MAX_CHUNKS_RESET;
         depth_ff      <= '0;
         bump_ff       <= '0;
         live_ff       <= '0;
         peak_ff       <= '0;
         chunk_ff      <= '0;
         cap_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         bump_ff      <= bump_in;
         live_ff      <= live_in;
         peak_ff      <= peak_in;
         chunk_ff     <= chunk_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= exec;
         if (csr_we) begin
            max_chunks_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         op_ff     <= req_data.op;
         target_ff <= req_data.target_index;
      end
   end

   // Free stack: read the top entry on accept, push on a successful release.
   always_ff @(posedge clock) begin
      if (accept) begin
         stack_rd_ff <= stack_mem[pop_ptr[IDX_W-1:0]];
      end
      if (stack_we) begin
         stack_mem[depth_ff[IDX_W-1:0]] <= target_ff[IDX_W-1:0];
      end
   end

   // Allocation bitmap: read the target bit on accept, update in the execute cycle.
   always_ff @(posedge clock) begin
      if (accept) begin
         bit_rd_ff <= bit_mem[IDX_W'(req_data.target_index)];
      end
      if (bit_we) begin
         bit_mem[bit_waddr] <= bit_wdata;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/bipa_checker.sv
`default_nettype none
`include "block_index_pool_allocator_assert.svh"

module bipa_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           start,
   input wire                           busy,
   input wire                           rsp_valid,
   input bipa_pkg::rsp_type             rsp_data
);

   logic rsp_exhausted;
   logic count_le_peak;

   assign rsp_exhausted = rsp_valid && (rsp_data.status == bipa_pkg::ST_EXHAUSTED);
   assign count_le_peak = (rsp_data.held_count <= rsp_data.high_water);

   `BIPA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   `BIPA_ASSERT_DELAY(a_latency, clock, reset, start && !busy, 2, rsp_valid)

   `BIPA_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)

   `BIPA_ASSERT_IMPLY(a_exhausted_zero, clock, reset, rsp_exhausted, rsp_data.granted_index == '0)

   `BIPA_ASSERT_IMPLY(a_count_le_peak, clock, reset, rsp_valid, count_le_peak)

endmodule

bind block_index_pool_allocator bipa_checker u_bipa_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// File: verif/tb_block_index_pool_allocator.sv
`default_nettype none

module tb_block_index_pool_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL_SIZE   = bipa_pkg::MAX_BLOCKS_DEFAULT;
   localparam int CHUNK_SIZE  = bipa_pkg::CHUNK_BLOCKS_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   bipa_pkg::req_type req_data = '0;
   logic rsp_valid;
   bipa_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [bipa_pkg::CHUNKS_W-1:0] csr_wdata = '0;

   // Shadow copy of the pool, updated when a request is accepted.
   logic [bipa_pkg::INDEX_W-1:0] free_list [POOL_SIZE];
   bit owned [POOL_SIZE];
   int unsigned free_top;
   int unsigned bump_ptr;
   int unsigned live_blocks;
   int unsigned peak_ptr;
   int unsigned grown_chunks;
   int unsigned chunk_limit;

   bipa_pkg::req_type request_q[$];
   bipa_pkg::rsp_type predicted_rsp_q[$];
   bit gaps_enabled = 1'b1;
   int idle_left = 0;
   int mismatch_count = 0;
   int rsp_seen = 0;
   int cycle_count = 0;

   block_index_pool_allocator u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2;
      clock = 1'b1;
      #2;
      clock = 1'b0;
   end

   function automatic void wipe_pool();
      foreach (owned[i]) owned[i] = 1'b0;
      free_top = 0;
      bump_ptr = 0;
      live_blocks = 0;
      peak_ptr = 0;
      grown_chunks = 0;
   endfunction

   function automatic bipa_pkg::rsp_type pool_step(bipa_pkg::req_type r);
      bipa_pkg::rsp_type res;
      int unsigned cap;
      int unsigned idx;
      res = '0;
      idx = r.target_index;
      case (r.op)
         bipa_pkg::OP_ALLOC: begin
            if (free_top > 0) begin
               free_top--;
               res.granted_index = free_list[free_top];
               owned[free_list[free_top]] = 1'b1;
               if (live_blocks < POOL_SIZE) live_blocks++;
            end else begin
               cap = grown_chunks * CHUNK_SIZE;
               // Growth is refused by the register or by the pool size itself.
               if (bump_ptr >= cap &&
                   (grown_chunks >= chunk_limit || cap + CHUNK_SIZE > POOL_SIZE)) begin
                  res.status = bipa_pkg::ST_EXHAUSTED;
               end else begin
                  if (bump_ptr >= cap) grown_chunks++;
                  res.granted_index = bump_ptr[bipa_pkg::INDEX_W-1:0];
                  owned[bump_ptr] = 1'b1;
                  bump_ptr++;
                  if (bump_ptr > peak_ptr) peak_ptr = bump_ptr;
                  if (live_blocks < POOL_SIZE) live_blocks++;
               end
            end
         end
         bipa_pkg::OP_RELEASE: begin
            if (idx < bump_ptr && owned[idx] && free_top < POOL_SIZE) begin
               free_list[free_top] = r.target_index;
               free_top++;
               owned[idx] = 1'b0;
               if (live_blocks > 0) live_blocks--;
            end else begin
               res.status = bipa_pkg::ST_NOT_HELD;
            end
         end
         bipa_pkg::OP_REWIND: begin
            free_top = 0;
            bump_ptr = 0;
            live_blocks = 0;
         end
         bipa_pkg::OP_CLEAR: wipe_pool();
         bipa_pkg::OP_QUERY: res.is_held = idx < bump_ptr && owned[idx];
         default: ;
      endcase
      res.held_count = live_blocks[bipa_pkg::COUNT_W-1:0];
      res.high_water = peak_ptr[bipa_pkg::COUNT_W-1:0];
      res.chunks_in_use = grown_chunks[bipa_pkg::CHUNKS_W-1:0];
      return res;
   endfunction

   // Mostly an index that is held right now, so releases get past the check.
   function automatic logic [bipa_pkg::INDEX_W-1:0] pick_live_index();
      int unsigned idx;
      idx = $urandom_range(0, POOL_SIZE - 1);
      for (int k = 0; k < 6 && bump_ptr != 0; k++)
         if (!(idx < bump_ptr && owned[idx])) idx = $urandom_range(0, bump_ptr - 1);
      return idx[bipa_pkg::INDEX_W-1:0];
   endfunction

   function automatic bipa_pkg::req_type make_request(int unsigned w_alloc,
                                                      int unsigned w_rel,
                                                      int unsigned w_qry,
                                                      int unsigned w_rew,
                                                      int unsigned w_clr);
      bipa_pkg::req_type r;
      int unsigned pick;
      int unsigned near;
      pick = $urandom_range(0, 99);
      r.target_index = $urandom_range(0, POOL_SIZE - 1);
      if (pick < w_alloc) begin
         r.op = bipa_pkg::OP_ALLOC;
      end else if (pick < w_alloc + w_rel) begin
         r.op = bipa_pkg::OP_RELEASE;
         if ($urandom_range(0, 3) != 0) r.target_index = pick_live_index();
      end else if (pick < w_alloc + w_rel + w_qry) begin
         r.op = bipa_pkg::OP_QUERY;
         if ($urandom_range(0, 1) != 0) begin
            near = $urandom_range(0, bump_ptr + 1);
            if (near > POOL_SIZE - 1) near = POOL_SIZE - 1;
            r.target_index = near[bipa_pkg::INDEX_W-1:0];
         end
      end else if (pick < w_alloc + w_rel + w_qry + w_rew) begin
         r.op = bipa_pkg::OP_REWIND;
      end else if (pick < w_alloc + w_rel + w_qry + w_rew + w_clr) begin
         r.op = bipa_pkg::OP_CLEAR;
      end else begin
         r.op = bipa_pkg::OP_W'(bipa_pkg::OP_QUERY + $urandom_range(1, 3));
      end
      return r;
   endfunction

   task automatic flag_mismatch(string what, int got, int want);
      $display("bipa tb: response %0d: %s got %0d expected %0d", rsp_seen, what, got, want);
      mismatch_count++;
   endtask

   task automatic queue_item(logic [bipa_pkg::OP_W-1:0] op, int unsigned idx);
      bipa_pkg::req_type r;
      r.op = op;
      r.target_index = idx[bipa_pkg::INDEX_W-1:0];
      request_q = {request_q, r};
   endtask

   task automatic wait_pool_idle();
      @(negedge clock);
      while (request_q.size() != 0 || start || predicted_rsp_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_chunk_limit(logic [bipa_pkg::CHUNKS_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_random(int n, int unsigned w_alloc, int unsigned w_rel,
                             int unsigned w_qry, int unsigned w_rew, int unsigned w_clr);
      while (n > 0) begin
         @(negedge clock);
         if (request_q.size() < 2) begin
            request_q = {request_q, make_request(w_alloc, w_rel, w_qry, w_rew, w_clr)};
            n--;
         end
      end
      wait_pool_idle();
   endtask

   // Driver: presents one transaction at a time and records what the pool should answer.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) chunk_limit = csr_wdata;
         if (start && !busy) begin
            predicted_rsp_q = {predicted_rsp_q, pool_step(req_data)};
            if (gaps_enabled && $urandom_range(0, 5) == 0) idle_left = $urandom_range(1, 15);
         end
         if (!start || !busy) begin
            if (idle_left > 0) begin
               idle_left--;
               start <= 1'b0;
            end else if (request_q.size() != 0) begin
               req_data <= request_q.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every response strobe is checked against the oldest prediction.
   always @(posedge clock) begin
      bipa_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         rsp_seen++;
         if (predicted_rsp_q.size() == 0) begin
            flag_mismatch("unexpected response, status", rsp_data.status, -1);
         end else begin
            want = predicted_rsp_q.pop_front();
            if (rsp_data.status !== want.status)
               flag_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.granted_index !== want.granted_index)
               flag_mismatch("granted_index", rsp_data.granted_index, want.granted_index);
            if (rsp_data.is_held !== want.is_held)
               flag_mismatch("is_held", rsp_data.is_held, want.is_held);
            if (rsp_data.held_count !== want.held_count)
               flag_mismatch("held_count", rsp_data.held_count, want.held_count);
            if (rsp_data.high_water !== want.high_water)
               flag_mismatch("high_water", rsp_data.high_water, want.high_water);
            if (rsp_data.chunks_in_use !== want.chunks_in_use)
               flag_mismatch("chunks_in_use", rsp_data.chunks_in_use, want.chunks_in_use);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[block_index_pool_allocator] ERROR");
         $finish;
      end
   end

   initial begin
      wipe_pool();
      chunk_limit = bipa_pkg::MAX_CHUNKS_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      // No growth allowed at all: the first allocate is already exhausted.
      set_chunk_limit(7'd0);
      queue_item(bipa_pkg::OP_ALLOC, 0);
      queue_item(bipa_pkg::OP_RELEASE, 0);
      queue_item(bipa_pkg::OP_QUERY, POOL_SIZE - 1);
      wait_pool_idle();

      // One chunk: fill it, run into exhaustion, then exercise the other operations.
      set_chunk_limit(7'd1);
      repeat (CHUNK_SIZE + 1) queue_item(bipa_pkg::OP_ALLOC, 0);
      queue_item(bipa_pkg::OP_RELEASE, CHUNK_SIZE - 1);
      queue_item(bipa_pkg::OP_RELEASE, CHUNK_SIZE - 1);
      queue_item(bipa_pkg::OP_RELEASE, POOL_SIZE - 1);
      queue_item(bipa_pkg::OP_QUERY, CHUNK_SIZE - 2);
      queue_item(bipa_pkg::OP_ALLOC, 0);
      queue_item(bipa_pkg::OP_W'(bipa_pkg::OP_QUERY + 3), POOL_SIZE - 1);
      queue_item(bipa_pkg::OP_REWIND, 0);
      queue_item(bipa_pkg::OP_QUERY, 3);
      queue_item(bipa_pkg::OP_CLEAR, 0);
      wait_pool_idle();

      set_chunk_limit(7'd64);
      run_random(250, 50, 30, 14, 2, 1);

      // Limit below the chunks already grown: the pool keeps its size.
      set_chunk_limit(7'd2);
      run_random(150, 60, 25, 10, 2, 1);

      // Oversized limit: only the pool size stops growth, so fill it completely.
      set_chunk_limit(7'd127);
      queue_item(bipa_pkg::OP_CLEAR, 0);
      run_random(1100, 97, 0, 2, 0, 0);

      set_chunk_limit(7'd0);
      run_random(150, 40, 45, 12, 1, 1);

      gaps_enabled = 1'b0;
      set_chunk_limit(7'd1);
      queue_item(bipa_pkg::OP_CLEAR, 0);
      run_random(150, 55, 25, 14, 2, 1);

      if (predicted_rsp_q.size() != 0)
         flag_mismatch("responses missing", 0, predicted_rsp_q.size());
      if (mismatch_count == 0) begin
         $display("[block_index_pool_allocator] OK");
      end else begin
         $display("[block_index_pool_allocator] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl/core
rtl/core/bipa_pkg.sv
rtl/core/block_index_pool_allocator.sv
rtl/core/bipa_checker.sv
verif/tb_block_index_pool_allocator.sv
